// ===== hw/rtl/saturating_q15_basic_alu_assert.svh =====
// ----------------------------------------------------------------------------
// saturating_q15_basic_alu_assert.svh
// assertion macros for the checker file of the saturating alu
// ----------------------------------------------------------------------------
`ifndef SATURATING_Q15_BASIC_ALU_ASSERT_SVH
`define SATURATING_Q15_BASIC_ALU_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define SQ15ALU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define SQ15ALU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sq15alu_pkg.sv =====
// ----------------------------------------------------------------------------
// sq15alu_pkg
// widths, opcodes and the 16-bit clamp of the saturating alu
// ----------------------------------------------------------------------------
package sq15alu_pkg;

	localparam int OPC_W       = 3;
	localparam int WIDE_W      = 32;
	localparam int DATA_W      = 16;
	localparam int MSU_W       = WIDE_W + 2;
	localparam int SHIFT_LIMIT = DATA_W - 1;
	localparam int CNT_W       = DATA_W + 1;
	localparam int SH_W        = $clog2(SHIFT_LIMIT);
	localparam int SHL_W       = DATA_W + SHIFT_LIMIT;

	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [OPC_W-1:0] {
		OPC_SAT = 3'd0,
		OPC_ADD = 3'd1,
		OPC_SUB = 3'd2,
		OPC_ABS = 3'd3,
		OPC_MSU = 3'd4,
		OPC_SHL = 3'd5,
		OPC_SHR = 3'd6
	} opcode_t;

	// clamp a wide signed value to 16 bits
	function automatic logic signed [DATA_W-1:0] sat16(input logic signed [MSU_W-1:0] v);
		logic fits;
		fits = (&v[MSU_W-1:DATA_W-1]) || !(|v[MSU_W-1:DATA_W-1]);
		if (fits) begin
			return v[DATA_W-1:0];
		end else if (v[MSU_W-1]) begin
			return DATA_MIN;
		end else begin
			return DATA_MAX;
		end
	endfunction

endpackage

// ===== hw/rtl/sq15alu_if.sv =====
// ----------------------------------------------------------------------------
// sq15alu_if
// valid/ready channels for operation and result transactions
// ----------------------------------------------------------------------------
interface sq15alu_cmd_if;
	logic                                        valid;
	logic                                        ready;
	logic [sq15alu_pkg::OPC_W-1:0]               opcode;
	logic signed [sq15alu_pkg::WIDE_W-1:0]       first_operand;
	logic signed [sq15alu_pkg::DATA_W-1:0]       second_operand;
	logic signed [sq15alu_pkg::DATA_W-1:0]       third_operand;

	modport source (output valid, opcode, first_operand, second_operand, third_operand,
		input ready);
	modport sink (input valid, opcode, first_operand, second_operand, third_operand,
		output ready);
endinterface

interface sq15alu_rsp_if;
	logic                                        valid;
	logic                                        ready;
	logic signed [sq15alu_pkg::DATA_W-1:0]       result;

	modport source (output valid, result, input ready);
	modport sink (input valid, result, output ready);
endinterface

// ===== hw/rtl/saturating_q15_basic_alu.sv =====
// ----------------------------------------------------------------------------
// saturating_q15_basic_alu
// saturating 16-bit fixed-point alu: saturate, add, sub, abs, msu, shifts
// ----------------------------------------------------------------------------
// One operation enters per clock unless the input side stalls, and its result is
// offered on the result channel from the result register: the operands are
// captured in an input register, evaluated by the single-pass datapath (one
// 16x16 multiplier for msu, adders, a barrel shifter and the clamp) and held in
// a result register. The input side stalls only when both registers hold data
// and the result is not taken; otherwise a new transaction is accepted every
// cycle. Opcode 7 returns zero.
// ----------------------------------------------------------------------------
module saturating_q15_basic_alu (
	input  logic                 clk,
	input  logic                 arst_n,
	sq15alu_cmd_if.sink          cmd,
	sq15alu_rsp_if.source        rsp
);

	logic                                    v_s1;
	logic [sq15alu_pkg::OPC_W-1:0]           opc_s1;
	logic signed [sq15alu_pkg::WIDE_W-1:0]   a_s1;
	logic signed [sq15alu_pkg::DATA_W-1:0]   b_s1;
	logic signed [sq15alu_pkg::DATA_W-1:0]   c_s1;
	logic                                    v_s2;
	logic signed [sq15alu_pkg::DATA_W-1:0]   res_s2;

	logic adv1;
	logic adv2;

	logic signed [sq15alu_pkg::DATA_W-1:0]   a16;
	logic signed [sq15alu_pkg::DATA_W:0]     a17;
	logic signed [sq15alu_pkg::DATA_W:0]     b17;
	logic signed [sq15alu_pkg::DATA_W:0]     sum17;
	logic signed [sq15alu_pkg::DATA_W:0]     dif17;
	logic signed [sq15alu_pkg::DATA_W:0]     abs17;
	logic signed [sq15alu_pkg::WIDE_W-1:0]   prod;
	logic signed [sq15alu_pkg::MSU_W-1:0]    msu;
	logic [sq15alu_pkg::CNT_W-1:0]           mag;
	logic                                    go_left;
	logic                                    long_sh;
	logic [sq15alu_pkg::SH_W-1:0]            sh;
	logic signed [sq15alu_pkg::DATA_W-1:0]   shr_val;
	logic signed [sq15alu_pkg::SHL_W-1:0]    shl_wide;
	logic signed [sq15alu_pkg::DATA_W-1:0]   shl_val;
	logic signed [sq15alu_pkg::DATA_W-1:0]   res_d;

	// handshake
	assign adv2      = !v_s2 || rsp.ready;
	assign adv1      = !v_s1 || adv2;
	assign cmd.ready = adv1;
	assign rsp.valid = v_s2;
	assign rsp.result = res_s2;

	// datapath
	assign a16   = a_s1[sq15alu_pkg::DATA_W-1:0];
	assign a17   = sq15alu_pkg::CNT_W'(a16);
	assign b17   = sq15alu_pkg::CNT_W'(b_s1);
	assign sum17 = a17 + b17;
	assign dif17 = a17 - b17;
	assign abs17 = a16[sq15alu_pkg::DATA_W-1] ? -a17 : a17;
	assign prod  = sq15alu_pkg::WIDE_W'(b_s1) * sq15alu_pkg::WIDE_W'(c_s1);
	assign msu   = sq15alu_pkg::MSU_W'(a_s1) - (sq15alu_pkg::MSU_W'(prod) <<< 1);

	// signed count: negative reverses direction, magnitude up to 32768
	assign mag     = b_s1[sq15alu_pkg::DATA_W-1] ? unsigned'(-b17) : unsigned'(b17);
	assign go_left = (opc_s1 == sq15alu_pkg::OPC_SHL) ^ b_s1[sq15alu_pkg::DATA_W-1];
	assign long_sh = mag >= sq15alu_pkg::CNT_W'(sq15alu_pkg::SHIFT_LIMIT);
	assign sh      = mag[sq15alu_pkg::SH_W-1:0];

	assign shr_val  = long_sh ? $signed({sq15alu_pkg::DATA_W{a16[sq15alu_pkg::DATA_W-1]}})
		: (a16 >>> sh);
	assign shl_wide = sq15alu_pkg::SHL_W'(a16) <<< sh;

	always_comb begin
		if (a16 == '0) begin
			shl_val = '0;
		end else if (long_sh) begin
			shl_val = a16[sq15alu_pkg::DATA_W-1] ? sq15alu_pkg::DATA_MIN : sq15alu_pkg::DATA_MAX;
		end else begin
			shl_val = sq15alu_pkg::sat16(sq15alu_pkg::MSU_W'(shl_wide));
		end
	end

	always_comb begin
		case (opc_s1)
			sq15alu_pkg::OPC_SAT: res_d = sq15alu_pkg::sat16(sq15alu_pkg::MSU_W'(a_s1));
			sq15alu_pkg::OPC_ADD: res_d = sq15alu_pkg::sat16(sq15alu_pkg::MSU_W'(sum17));
			sq15alu_pkg::OPC_SUB: res_d = sq15alu_pkg::sat16(sq15alu_pkg::MSU_W'(dif17));
			sq15alu_pkg::OPC_ABS: res_d = sq15alu_pkg::sat16(sq15alu_pkg::MSU_W'(abs17));
			sq15alu_pkg::OPC_MSU: res_d = sq15alu_pkg::sat16(msu);
			sq15alu_pkg::OPC_SHL,
			sq15alu_pkg::OPC_SHR: res_d = go_left ? shl_val : shr_val;
			default:              res_d = '0;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && cmd.valid) begin
			opc_s1 <= cmd.opcode;
			a_s1   <= cmd.first_operand;
			b_s1   <= cmd.second_operand;
			c_s1   <= cmd.third_operand;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			res_s2 <= res_d;
		end
	end

endmodule

// ===== hw/rtl/sq15alu_chk.sv =====
// ----------------------------------------------------------------------------
// sq15alu_chk
// port-level checks of the saturating alu, bound to the top level
// ----------------------------------------------------------------------------
`include "saturating_q15_basic_alu_assert.svh"

module sq15alu_chk (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cmd_valid,
	input  logic                                  cmd_ready,
	input  logic                                  rsp_valid,
	input  logic                                  rsp_ready,
	input  logic signed [sq15alu_pkg::DATA_W-1:0] rsp_result
);

	logic cmd_acc;

	assign cmd_acc = cmd_valid && cmd_ready;

	// a stalled result transaction stays offered
	`SQ15ALU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
	// and keeps its value
	`SQ15ALU_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_result), "result changed while stalled")
	// the input side only stalls behind a blocked result
	`SQ15ALU_ASSERT_NOW(a_no_false_stall, !cmd_ready, rsp_valid && !rsp_ready, "input stalled without backpressure")
	// with no input accepted and the result taken, the input and result registers drain
	`SQ15ALU_ASSERT_NEXT(a_drain, (!cmd_acc && rsp_ready) ##1 (!cmd_acc && rsp_ready), !rsp_valid, "result without a transaction")

endmodule

bind saturating_q15_basic_alu sq15alu_chk u_sq15alu_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_result (rsp.result)
);
